// ===== rtl/video_register_port_and_timing_defines.svh =====
// assertion macros shared by the video register port modules
`ifndef VIDEO_REGISTER_PORT_AND_TIMING_DEFINES_SVH
`define VIDEO_REGISTER_PORT_AND_TIMING_DEFINES_SVH

// condition must hold in the same cycle
`define VRPT_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// condition must hold in the cycle after
`define VRPT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/vrpt_pkg.sv =====
// shared types and constants for the video register port
package vrpt_pkg;

  localparam int PATTERN_BYTES   = 8192;
  localparam int NAMETABLE_BYTES = 2048;
  localparam int OBJECT_BYTES    = 256;
  localparam int PALETTE_BYTES   = 32;

  localparam int PAT_AW = $clog2(PATTERN_BYTES);
  localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
  localparam int OBJ_AW = $clog2(OBJECT_BYTES);
  localparam int PAL_AW = $clog2(PALETTE_BYTES);

  localparam int CLEAR_DEPTH = (PATTERN_BYTES > NAMETABLE_BYTES) ? PATTERN_BYTES
                                                                 : NAMETABLE_BYTES;
  localparam int CLEAR_W     = $clog2(CLEAR_DEPTH);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [9:0]  DOTS_PER_LINE   = 10'd341;
  localparam logic [8:0]  VBLANK_LINE     = 9'd241;
  localparam logic [8:0]  LINES_PER_FRAME = 9'd262;
  localparam logic [13:0] NT_BASE         = 14'h2000;
  localparam logic [13:0] PAL_BASE        = 14'h3F00;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_OAMADDR = 3'd3;
  localparam logic [2:0] REG_OAMDATA = 3'd4;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_ADDR    = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  typedef enum logic [3:0] {
    K_NONE,
    K_CTRL_WR,
    K_MASK_WR,
    K_OAMADDR_WR,
    K_OAMDATA_WR,
    K_ADDR_WR,
    K_DATA_WR,
    K_STATUS_RD,
    K_OAM_RD,
    K_DATA_RD,
    K_TICK
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] arg;
  } item_t;

endpackage

// ===== rtl/video_register_port_and_timing.sv =====
// items go through a queue entry to the result register, one per cycle while the
// result is taken; oam and data-port reads pass the wait state for the registered read
// the back end handles one item at a time; a two-entry queue decouples it from the input
// reset: synchronous, active high; afterwards a clearing pass zeroes the pattern,
// nametable and object memories, and no input transfer is taken until it ends
module video_register_port_and_timing (
  input  logic        clk,
  input  logic        rst,
  // configuration: mirroring select
  input  logic        cfg_wen,
  input  logic        cfg_wdata,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] write_data, [15:8] tick_dots
  input  logic [4:0]  s_tuser,   // [1:0] opcode, [4:2] reg_index
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] read_data, [8] nmi_pending, [15:9] zero
  output logic        m_tlast    // frame_done
);

  logic            mirror_vertical;
  logic            front_ready;
  logic            front_valid;
  logic            clear_done;
  logic            item_pop;
  vrpt_pkg::item_t item;
  logic [7:0]      read_data;
  logic            nmi_pending;

  // mirroring register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_vertical <= 1'b0;
    end else if (cfg_wen) begin
      mirror_vertical <= cfg_wdata;
    end
  end

  // no input transfer while the memories are being cleared
  assign s_tready = front_ready && clear_done;

  // front end: decode and queue
  vrpt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid && clear_done),
    .in_ready   (front_ready),
    .opcode     (s_tuser[1:0]),
    .reg_index  (s_tuser[4:2]),
    .write_data (s_tdata[7:0]),
    .tick_dots  (s_tdata[15:8]),
    .out_valid  (front_valid),
    .out_pop    (item_pop),
    .out_item   (item)
  );

  // back end: registers, memories, timing and result register
  vrpt_back u_back (
    .clk             (clk),
    .rst             (rst),
    .mirror_vertical (mirror_vertical),
    .item_valid      (front_valid),
    .item            (item),
    .item_pop        (item_pop),
    .clear_done      (clear_done),
    .m_valid         (m_tvalid),
    .m_ready         (m_tready),
    .m_read_data     (read_data),
    .m_nmi_pending   (nmi_pending),
    .m_frame_done    (m_tlast)
  );

  // pack result fields, padding to whole bytes
  assign m_tdata = {7'b0000000, nmi_pending, read_data};

endmodule

// ===== rtl/vrpt_front.sv =====
// front end: classifies bus accesses and ticks and queues them
`include "video_register_port_and_timing_defines.svh"
module vrpt_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      opcode,
  input  logic [2:0]      reg_index,
  input  logic [7:0]      write_data,
  input  logic [7:0]      tick_dots,
  output logic            out_valid,
  input  logic            out_pop,
  output vrpt_pkg::item_t out_item
);

  vrpt_pkg::item_t                 q [vrpt_pkg::QUEUE_DEPTH];
  logic [vrpt_pkg::QPTR_W-1:0]     wr_ptr;
  logic [vrpt_pkg::QPTR_W-1:0]     rd_ptr;
  logic [vrpt_pkg::QCNT_W-1:0]     count;
  vrpt_pkg::item_t                 cls;
  logic                            push;

  always_comb begin
    cls.kind = vrpt_pkg::K_NONE;
    cls.arg  = write_data;
    unique case (opcode)
      vrpt_pkg::OP_WRITE: begin
        unique case (reg_index)
          vrpt_pkg::REG_CTRL:    cls.kind = vrpt_pkg::K_CTRL_WR;
          vrpt_pkg::REG_MASK:    cls.kind = vrpt_pkg::K_MASK_WR;
          vrpt_pkg::REG_OAMADDR: cls.kind = vrpt_pkg::K_OAMADDR_WR;
          vrpt_pkg::REG_OAMDATA: cls.kind = vrpt_pkg::K_OAMDATA_WR;
          vrpt_pkg::REG_ADDR:    cls.kind = vrpt_pkg::K_ADDR_WR;
          vrpt_pkg::REG_DATA:    cls.kind = vrpt_pkg::K_DATA_WR;
          default:               cls.kind = vrpt_pkg::K_NONE;
        endcase
      end
      vrpt_pkg::OP_READ: begin
        unique case (reg_index)
          vrpt_pkg::REG_STATUS:  cls.kind = vrpt_pkg::K_STATUS_RD;
          vrpt_pkg::REG_OAMDATA: cls.kind = vrpt_pkg::K_OAM_RD;
          vrpt_pkg::REG_DATA:    cls.kind = vrpt_pkg::K_DATA_RD;
          default:               cls.kind = vrpt_pkg::K_NONE;
        endcase
      end
      vrpt_pkg::OP_TICK: begin
        cls.kind = vrpt_pkg::K_TICK;
        cls.arg  = tick_dots;
      end
      default: cls.kind = vrpt_pkg::K_NONE;
    endcase
  end

  assign in_ready  = (count != vrpt_pkg::QCNT_W'(vrpt_pkg::QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == vrpt_pkg::QPTR_W'(vrpt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (out_pop) begin
        rd_ptr <= (rd_ptr == vrpt_pkg::QPTR_W'(vrpt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !out_pop) begin
        count <= count + 1'b1;
      end else if (!push && out_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  `VRPT_ASSERT_NOW(a_pop_needs_entry, out_pop, count != '0, "pop from empty queue")
  `VRPT_ASSERT_NOW(a_count_bound, 1'b1, count <= vrpt_pkg::QCNT_W'(vrpt_pkg::QUEUE_DEPTH), "queue overfilled")
  `VRPT_ASSERT_NEXT(a_push_lands, push && !out_pop, count != '0, "pushed item lost")

endmodule

// ===== rtl/vrpt_back.sv =====
// back end: register file, video memories, line timing and result register
`include "video_register_port_and_timing_defines.svh"
module vrpt_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            mirror_vertical,
  input  logic            item_valid,
  input  vrpt_pkg::item_t item,
  output logic            item_pop,
  output logic            clear_done,
  output logic            m_valid,
  input  logic            m_ready,
  output logic [7:0]      m_read_data,
  output logic            m_nmi_pending,
  output logic            m_frame_done
);

  typedef enum logic [1:0] {S_CLEAR, S_RUN, S_WAIT} state_t;

  state_t state, state_next;
  logic [vrpt_pkg::CLEAR_W-1:0] clr_cnt, clr_cnt_next;

  logic [7:0]  pat_mem [vrpt_pkg::PATTERN_BYTES];
  logic [7:0]  nt_mem  [vrpt_pkg::NAMETABLE_BYTES];
  logic [7:0]  obj_mem [vrpt_pkg::OBJECT_BYTES];
  logic [7:0]  palette [vrpt_pkg::PALETTE_BYTES];
  logic [7:0]  pat_q, nt_q, obj_q;

  logic [7:0]  obj_ptr, obj_ptr_next;
  logic [7:0]  obj0, obj0_next, obj3, obj3_next;
  logic [13:0] vram_addr, vram_addr_next;
  logic        toggle, toggle_next;
  logic [7:0]  read_buffer, read_buffer_next;
  logic [7:0]  control, control_next;
  logic        show_sprites, show_sprites_next;
  logic        vblank, vblank_next;
  logic        hit, hit_next;
  logic        nmi, nmi_next;
  logic [9:0]  dot_count, dot_count_next;
  logic [8:0]  line_count, line_count_next;
  logic        pend_oam, pend_oam_next;
  logic        pend_pat, pend_pat_next;
  logic        pend_pal, pend_pal_next;
  logic [7:0]  pal_hold, pal_hold_next;
  logic        m_valid_next, m_nmi_next, m_done_next;
  logic [7:0]  m_read_next;

  logic        clearing, start;
  logic        is_pat, is_pal;
  logic [vrpt_pkg::NT_AW-1:0]  nt_idx;
  logic [vrpt_pkg::PAL_AW-1:0] pal_idx;
  logic [13:0] vram_step;
  logic [9:0]  dot_sum;
  logic [8:0]  line_inc;
  logic        sprite_hit;
  logic        pat_we, nt_we, obj_we, pal_we;
  logic [7:0]  wdata;
  logic [7:0]  rd_val;
  logic        done_val;

  assign clearing   = (state == S_CLEAR);
  assign clear_done = !clearing;
  assign start      = (state == S_RUN) && item_valid && (!m_valid || m_ready);
  assign item_pop   = start;

  // region decode; 0x3000 range and palette-shadow reads share the nametable index
  assign is_pat  = (vram_addr < vrpt_pkg::NT_BASE);
  assign is_pal  = (vram_addr >= vrpt_pkg::PAL_BASE);
  assign nt_idx  = {(mirror_vertical ? vram_addr[10] : vram_addr[11]), vram_addr[9:0]};
  assign pal_idx = (vram_addr[4] && (vram_addr[1:0] == 2'b00)) ? {1'b0, vram_addr[3:0]}
                                                                : vram_addr[4:0];
  assign vram_step = vram_addr + (control[2] ? 14'd32 : 14'd1);

  assign dot_sum    = dot_count + {2'b00, item.arg};
  assign line_inc   = line_count + 9'd1;
  assign sprite_hit = show_sprites && (line_count == {1'b0, obj0}) && ({2'b00, obj3} <= dot_sum);

  assign wdata  = clearing ? 8'h00 : item.arg;
  assign pat_we = clearing || (start && (item.kind == vrpt_pkg::K_DATA_WR) && is_pat);
  assign nt_we  = clearing || (start && (item.kind == vrpt_pkg::K_DATA_WR) && !is_pat && !is_pal);
  assign pal_we = start && (item.kind == vrpt_pkg::K_DATA_WR) && is_pal;
  assign obj_we = clearing || (start && (item.kind == vrpt_pkg::K_OAMDATA_WR));

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[clearing ? clr_cnt[vrpt_pkg::PAT_AW-1:0] : vram_addr[vrpt_pkg::PAT_AW-1:0]] <= wdata;
    end
    pat_q <= pat_mem[vram_addr[vrpt_pkg::PAT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (nt_we) begin
      nt_mem[clearing ? clr_cnt[vrpt_pkg::NT_AW-1:0] : nt_idx] <= wdata;
    end
    nt_q <= nt_mem[nt_idx];
  end

  always_ff @(posedge clk) begin
    if (obj_we) begin
      obj_mem[clearing ? clr_cnt[vrpt_pkg::OBJ_AW-1:0] : obj_ptr] <= wdata;
    end
    obj_q <= obj_mem[obj_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vrpt_pkg::PALETTE_BYTES; i++) begin
        palette[i] <= 8'h00;
      end
    end else if (pal_we) begin
      palette[pal_idx] <= item.arg;
    end
  end

  always_comb begin
    state_next        = state;
    clr_cnt_next      = clr_cnt;
    obj_ptr_next      = obj_ptr;
    obj0_next         = obj0;
    obj3_next         = obj3;
    vram_addr_next    = vram_addr;
    toggle_next       = toggle;
    read_buffer_next  = read_buffer;
    control_next      = control;
    show_sprites_next = show_sprites;
    vblank_next       = vblank;
    hit_next          = hit;
    nmi_next          = nmi;
    dot_count_next    = dot_count;
    line_count_next   = line_count;
    pend_oam_next     = pend_oam;
    pend_pat_next     = pend_pat;
    pend_pal_next     = pend_pal;
    pal_hold_next     = pal_hold;
    m_valid_next      = m_valid && !m_ready;
    m_read_next       = m_read_data;
    m_nmi_next        = m_nmi_pending;
    m_done_next       = m_frame_done;
    rd_val            = 8'h00;
    done_val          = 1'b0;
    unique case (state)
      S_CLEAR: begin
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == vrpt_pkg::CLEAR_W'(vrpt_pkg::CLEAR_DEPTH - 1)) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (start) begin
          unique case (item.kind)
            vrpt_pkg::K_CTRL_WR: begin
              control_next = item.arg;
              if (!control[7] && item.arg[7] && vblank) nmi_next = 1'b1;
            end
            vrpt_pkg::K_MASK_WR: show_sprites_next = item.arg[4];
            vrpt_pkg::K_OAMADDR_WR: obj_ptr_next = item.arg;
            vrpt_pkg::K_OAMDATA_WR: begin
              obj_ptr_next = obj_ptr + 8'd1;
              if (obj_ptr == 8'd0) obj0_next = item.arg;
              if (obj_ptr == 8'd3) obj3_next = item.arg;
            end
            vrpt_pkg::K_ADDR_WR: begin
              vram_addr_next = toggle ? {vram_addr[13:8], item.arg}
                                      : {item.arg[5:0], vram_addr[7:0]};
              toggle_next    = !toggle;
            end
            vrpt_pkg::K_DATA_WR: vram_addr_next = vram_step;
            vrpt_pkg::K_STATUS_RD: begin
              rd_val      = {vblank, hit, 6'b000000};
              vblank_next = 1'b0;
              toggle_next = 1'b0;
            end
            vrpt_pkg::K_OAM_RD: begin
              pend_oam_next = 1'b1;
              state_next    = S_WAIT;
            end
            vrpt_pkg::K_DATA_RD: begin
              pend_oam_next  = 1'b0;
              pend_pat_next  = is_pat;
              pend_pal_next  = is_pal;
              pal_hold_next  = palette[pal_idx];
              vram_addr_next = vram_step;
              state_next     = S_WAIT;
            end
            vrpt_pkg::K_TICK: begin
              dot_count_next = dot_sum;
              if (dot_sum >= vrpt_pkg::DOTS_PER_LINE) begin
                if (sprite_hit) hit_next = 1'b1;
                dot_count_next  = dot_sum - vrpt_pkg::DOTS_PER_LINE;
                line_count_next = line_inc;
                if (line_inc == vrpt_pkg::VBLANK_LINE) begin
                  vblank_next = 1'b1;
                  hit_next    = 1'b0;
                  if (control[7]) nmi_next = 1'b1;
                end else if (line_inc >= vrpt_pkg::LINES_PER_FRAME) begin
                  line_count_next = 9'd0;
                  nmi_next        = 1'b0;
                  vblank_next     = 1'b0;
                  hit_next        = 1'b0;
                  done_val        = 1'b1;
                end
              end
            end
            default: ;
          endcase
          if ((item.kind != vrpt_pkg::K_OAM_RD) && (item.kind != vrpt_pkg::K_DATA_RD)) begin
            m_valid_next = 1'b1;
            m_read_next  = rd_val;
            m_nmi_next   = nmi_next;
            m_done_next  = done_val;
          end
        end
      end
      S_WAIT: begin
        if (pend_oam) begin
          rd_val = obj_q;
        end else begin
          rd_val           = pend_pal ? pal_hold : read_buffer;
          read_buffer_next = pend_pat ? pat_q : nt_q;
        end
        m_valid_next = 1'b1;
        m_read_next  = rd_val;
        m_nmi_next   = nmi;
        m_done_next  = 1'b0;
        state_next   = S_RUN;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      obj_ptr      <= 8'd0;
      obj0         <= 8'd0;
      obj3         <= 8'd0;
      vram_addr    <= 14'd0;
      toggle       <= 1'b0;
      read_buffer  <= 8'd0;
      control      <= 8'd0;
      show_sprites <= 1'b0;
      vblank       <= 1'b0;
      hit          <= 1'b0;
      nmi          <= 1'b0;
      dot_count    <= 10'd0;
      line_count   <= 9'd0;
      m_valid      <= 1'b0;
    end else begin
      state        <= state_next;
      clr_cnt      <= clr_cnt_next;
      obj_ptr      <= obj_ptr_next;
      obj0         <= obj0_next;
      obj3         <= obj3_next;
      vram_addr    <= vram_addr_next;
      toggle       <= toggle_next;
      read_buffer  <= read_buffer_next;
      control      <= control_next;
      show_sprites <= show_sprites_next;
      vblank       <= vblank_next;
      hit          <= hit_next;
      nmi          <= nmi_next;
      dot_count    <= dot_count_next;
      line_count   <= line_count_next;
      m_valid      <= m_valid_next;
    end
    pend_oam      <= pend_oam_next;
    pend_pat      <= pend_pat_next;
    pend_pal      <= pend_pal_next;
    pal_hold      <= pal_hold_next;
    m_read_data   <= m_read_next;
    m_nmi_pending <= m_nmi_next;
    m_frame_done  <= m_done_next;
  end

  `VRPT_ASSERT_NOW(a_no_pop_in_clear, state == S_CLEAR, !item_pop, "item taken during clear")
  `VRPT_ASSERT_NEXT(a_wait_delivers, state == S_WAIT, m_valid, "memory read gave no result")
  `VRPT_ASSERT_NOW(a_line_range, 1'b1, line_count < vrpt_pkg::LINES_PER_FRAME, "line out of range")
  `VRPT_ASSERT_NOW(a_dot_range, 1'b1, dot_count < vrpt_pkg::DOTS_PER_LINE, "dot out of range")

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the video register port and line timing block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic        cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [7:0] write_data, [15:8] tick_dots
  logic [4:0]  s_tuser;   // [1:0] opcode, [4:2] reg_index
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [7:0] read_data, [8] nmi_pending, [15:9] zero
  logic        m_tlast;   // frame_done

  video_register_port_and_timing u_dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // one bus access or tick
  typedef struct {
    logic [1:0] op;
    logic [2:0] rsel;
    logic [7:0] wbyte;
    logic [7:0] dots;
  } access_t;

  // one reply
  typedef struct {
    logic [7:0] rbyte;
    logic       nmi;
    logic       frame;
  } reply_t;

  // directed row: access plus optional typed-in reply
  typedef struct {
    access_t acc;
    bit      known;
    reply_t  rep;
  } row_t;

  // shadow state of the block
  logic [7:0]  pat_mem [vrpt_pkg::PATTERN_BYTES];
  logic [7:0]  nt_mem [vrpt_pkg::NAMETABLE_BYTES];
  logic [7:0]  pal_mem [vrpt_pkg::PALETTE_BYTES];
  logic [7:0]  obj_mem [vrpt_pkg::OBJECT_BYTES];
  logic [7:0]  obj_ptr;
  logic [13:0] vaddr;
  logic        low_next;
  logic [7:0]  rbuf;
  logic [7:0]  ctrl;
  logic        spr_show;
  logic        vblank;
  logic        spr_hit;
  logic        nmi;
  logic [9:0]  dot;
  logic [8:0]  line;
  logic        mirror_v;

  reply_t  replies_due[$];
  access_t feed[$];
  int      errors = 0;
  int      replies_seen = 0;
  int      frames_seen = 0;
  int      cycle = 0;
  int      send_idle = 0;   // percent of cycles the sender idles
  int      recv_idle = 0;   // percent of cycles the receiver stalls
  int      hold_off = 0;    // long receiver hold-off, in cycles
  bit      hold_req = 0;    // asks the receiver for one long hold-off
  bit      hold_taken = 0;
  bit      feed_done = 0;

  function automatic int nt_slot(logic [13:0] a);
    int idx;
    int tbl;
    idx = int'(a & 14'h0FFF);
    tbl = idx / 'h400;
    if (mirror_v) begin
      if (tbl >= 2) idx -= 'h800;
    end else begin
      if (tbl == 1 || tbl == 2) idx -= 'h400;
      else if (tbl == 3) idx -= 'h800;
    end
    return idx % vrpt_pkg::NAMETABLE_BYTES;
  endfunction

  function automatic int pal_slot(logic [13:0] a);
    int idx;
    idx = int'(a & 14'h001F);
    if ((idx & 'h13) == 'h10) idx &= 'h0F;
    return idx;
  endfunction

  function automatic void bump_vaddr();
    vaddr = vaddr + (ctrl[2] ? 14'd32 : 14'd1);
  endfunction

  function automatic void clear_shadow();
    foreach (pat_mem[i]) pat_mem[i] = '0;
    foreach (nt_mem[i]) nt_mem[i] = '0;
    foreach (pal_mem[i]) pal_mem[i] = '0;
    foreach (obj_mem[i]) obj_mem[i] = '0;
    obj_ptr = 0; vaddr = 0; low_next = 0; rbuf = 0; ctrl = 0;
    spr_show = 0; vblank = 0; spr_hit = 0; nmi = 0; dot = 0; line = 0;
    mirror_v = 0;
  endfunction

  // predict the reply of one access and update the shadow state
  function automatic reply_t predict_access(access_t x);
    reply_t     r;
    logic [13:0] a;
    logic [10:0] sum;
    r.rbyte = 0;
    r.frame = 0;
    a = vaddr;
    if (x.op == vrpt_pkg::OP_WRITE) begin
      case (x.rsel)
        vrpt_pkg::REG_CTRL: begin
          if (!ctrl[7] && x.wbyte[7] && vblank) nmi = 1;
          ctrl = x.wbyte;
        end
        vrpt_pkg::REG_MASK: spr_show = x.wbyte[4];
        vrpt_pkg::REG_OAMADDR: obj_ptr = x.wbyte;
        vrpt_pkg::REG_OAMDATA: begin
          obj_mem[obj_ptr] = x.wbyte;
          obj_ptr++;
        end
        vrpt_pkg::REG_ADDR: begin
          if (!low_next) vaddr = {x.wbyte[5:0], vaddr[7:0]};
          else vaddr = {vaddr[13:8], x.wbyte};
          low_next = ~low_next;
        end
        vrpt_pkg::REG_DATA: begin
          if (a < vrpt_pkg::NT_BASE) pat_mem[a % vrpt_pkg::PATTERN_BYTES] = x.wbyte;
          else if (a < vrpt_pkg::PAL_BASE) nt_mem[nt_slot(a)] = x.wbyte;
          else pal_mem[pal_slot(a)] = x.wbyte;
          bump_vaddr();
        end
        default: ;
      endcase
    end else if (x.op == vrpt_pkg::OP_READ) begin
      case (x.rsel)
        vrpt_pkg::REG_STATUS: begin
          r.rbyte = {vblank, spr_hit, 6'd0};
          vblank = 0;
          low_next = 0;
        end
        vrpt_pkg::REG_OAMDATA: r.rbyte = obj_mem[obj_ptr];
        vrpt_pkg::REG_DATA: begin
          bump_vaddr();
          if (a < vrpt_pkg::NT_BASE) begin
            r.rbyte = rbuf; rbuf = pat_mem[a % vrpt_pkg::PATTERN_BYTES];
          end else if (a < vrpt_pkg::PAL_BASE) begin
            r.rbyte = rbuf; rbuf = nt_mem[nt_slot(a)];
          end else begin
            r.rbyte = pal_mem[pal_slot(a)];
            rbuf = nt_mem[nt_slot(a - 14'h1000)];
          end
        end
        default: ;
      endcase
    end else if (x.op == vrpt_pkg::OP_TICK) begin
      sum = {1'b0, dot} + {3'b000, x.dots};
      dot = sum[9:0];
      if (dot >= vrpt_pkg::DOTS_PER_LINE) begin
        if (spr_show && line == {1'b0, obj_mem[0]} && {2'b00, obj_mem[3]} <= dot) spr_hit = 1;
        dot = dot - vrpt_pkg::DOTS_PER_LINE;
        line++;
        if (line == vrpt_pkg::VBLANK_LINE) begin
          vblank = 1; spr_hit = 0;
          if (ctrl[7]) nmi = 1;
        end else if (line >= vrpt_pkg::LINES_PER_FRAME) begin
          line = 0; nmi = 0; vblank = 0; spr_hit = 0;
          r.frame = 1;
        end
      end
    end
    r.nmi = nmi;
    return r;
  endfunction

  function automatic access_t mk(logic [1:0] op, logic [2:0] rs, logic [7:0] wb,
                                 logic [7:0] dt);
    access_t x;
    x.op = op; x.rsel = rs; x.wbyte = wb; x.dots = dt;
    return x;
  endfunction

  // random access, mostly meaningful sequences around the data port and timing
  function automatic void push_random();
    int pick;
    logic [13:0] a;
    pick = int'($urandom_range(0, 99));
    if (pick < 30) begin
      // set an address, aimed at every region, then a few data accesses
      case ($urandom_range(0, 3))
        0: a = 14'($urandom_range(0, 'h1FFF));
        1: a = 14'($urandom_range('h2000, 'h2FFF));
        2: a = 14'($urandom_range('h3000, 'h3EFF));
        default: a = 14'($urandom_range('h3F00, 'h3FFF));
      endcase
      if ($urandom_range(0, 3) == 0) a[13:12] = 2'($urandom);
      feed.push_back(mk(vrpt_pkg::OP_READ, vrpt_pkg::REG_STATUS, 8'($urandom),
                        8'($urandom)));
      feed.push_back(mk(vrpt_pkg::OP_WRITE, vrpt_pkg::REG_ADDR,
                        {2'($urandom_range(0, 3)), a[13:8]}, 8'($urandom)));
      feed.push_back(mk(vrpt_pkg::OP_WRITE, vrpt_pkg::REG_ADDR, a[7:0], 8'($urandom)));
      repeat ($urandom_range(1, 4))
        feed.push_back(mk(2'($urandom_range(0, 1)), vrpt_pkg::REG_DATA, 8'($urandom),
                          8'($urandom)));
    end else if (pick < 60) begin
      // ticks, big enough to walk through whole frames
      feed.push_back(mk(vrpt_pkg::OP_TICK, 3'($urandom), 8'($urandom),
                        8'($urandom_range(128, 255))));
    end else if (pick < 70) begin
      feed.push_back(mk(vrpt_pkg::OP_WRITE, vrpt_pkg::REG_OAMADDR,
                        $urandom_range(0, 1) ? 8'd0 : 8'($urandom), 8'($urandom)));
      repeat ($urandom_range(1, 4))
        feed.push_back(mk($urandom_range(0, 1) ? vrpt_pkg::OP_WRITE : vrpt_pkg::OP_READ,
                          vrpt_pkg::REG_OAMDATA,
                          $urandom_range(0, 1) ? 8'($urandom_range(0, 20)) : 8'($urandom),
                          8'($urandom)));
    end else if (pick < 80) begin
      feed.push_back(mk(vrpt_pkg::OP_WRITE,
                        $urandom_range(0, 1) ? vrpt_pkg::REG_CTRL : vrpt_pkg::REG_MASK,
                        8'($urandom), 8'($urandom)));
    end else begin
      // noise over every code, the unused opcode included
      feed.push_back(mk(2'($urandom), 3'($urandom), 8'($urandom), 8'($urandom)));
    end
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // cycle counter and run limit
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 600000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // sender: one transfer offered at a time, prediction taken at acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        replies_due.push_back(predict_access(feed.pop_front()));
      end
      if (!s_tvalid || s_tready) begin
        if (feed.size() > 0 && ($urandom_range(0, 99) >= send_idle)) begin
          s_tvalid <= 1;
          s_tdata  <= {feed[0].dots, feed[0].wbyte};
          s_tuser  <= {feed[0].rsel, feed[0].op};
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // receiver with its own hold-off counter
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1;
      hold_off   <= 400;
      m_tready   <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // checker
  always @(posedge clk) begin
    reply_t e;
    if (!rst && m_tvalid && m_tready) begin
      replies_seen++;
      if (m_tlast) frames_seen++;
      if (replies_due.size() == 0) begin
        $error("reply with none expected");
        errors++;
      end else begin
        e = replies_due.pop_front();
        if (m_tdata[7:0] !== e.rbyte) begin
          $error("read_data expected %0h actual %0h", e.rbyte, m_tdata[7:0]); errors++;
        end
        if (m_tdata[8] !== e.nmi) begin
          $error("nmi_pending expected %0b actual %0b", e.nmi, m_tdata[8]); errors++;
        end
        if (m_tlast !== e.frame) begin
          $error("frame_done expected %0b actual %0b", e.frame, m_tlast); errors++;
        end
        if (m_tdata[15:9] !== 7'd0) begin
          $error("tdata pad expected 0 actual %0h", m_tdata[15:9]); errors++;
        end
      end
    end
  end

  // wait until every queued access has been sent and answered
  task automatic drain();
    int n;
    feed_done = 1;
    while (feed.size() > 0 || s_tvalid || replies_due.size() > 0) @(posedge clk);
    for (n = 0; n < 8; n++) @(posedge clk);
  endtask

  task automatic set_mirror(logic v);
    @(posedge clk);
    cfg_wen   <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 0;
    mirror_v = v;
  endtask

  // queue about n accesses, then let them all complete
  task automatic random_phase(int n, int si, int ri);
    send_idle = si;
    recv_idle = ri;
    while (feed.size() < n) push_random();
    drain();
  endtask

  row_t rows[$];

  function automatic void add_row(access_t x, bit k, logic [7:0] rb, logic nm, logic fr);
    row_t r;
    r.acc = x; r.known = k; r.rep.rbyte = rb; r.rep.nmi = nm; r.rep.frame = fr;
    rows.push_back(r);
  endfunction

  initial begin
    reply_t chk;
    int     k;
    rst = 1; cfg_wen = 0; cfg_wdata = 0;
    s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 0;
    clear_shadow();
    repeat (5) @(posedge clk);
    rst <= 0;
    set_mirror(0);

    // directed table: after-reset reads, write-only reads, ignored writes,
    // palette aliases, 0x3000 mirror, extremes of every field
    add_row(mk(vrpt_pkg::OP_READ, vrpt_pkg::REG_STATUS, 8'h00, 8'h00), 1, 8'h00, 0, 0);
    add_row(mk(vrpt_pkg::OP_READ, vrpt_pkg::REG_CTRL, 8'hFF, 8'hFF), 1, 8'h00, 0, 0);
    add_row(mk(vrpt_pkg::OP_READ, vrpt_pkg::REG_MASK, 8'h00, 8'h00), 1, 8'h00, 0, 0);
    add_row(mk(vrpt_pkg::OP_READ, vrpt_pkg::REG_OAMADDR, 8'h00, 8'h00), 1, 8'h00, 0, 0);
    add_row(mk(vrpt_pkg::OP_READ, vrpt_pkg::REG_SCROLL, 8'h00, 8'h00), 1, 8'h00, 0, 0);
    add_row(mk(vrpt_pkg::OP_READ, vrpt_pkg::REG_ADDR, 8'h00, 8'h00), 1, 8'h00, 0, 0);
    add_row(mk(vrpt_pkg::OP_READ, vrpt_pkg::REG_OAMDATA, 8'h00, 8'h00), 1, 8'h00, 0, 0);
    add_row(mk(2'd3, 3'd7, 8'hFF, 8'hFF), 1, 8'h00, 0, 0);
    add_row(mk(vrpt_pkg::OP_WRITE, vrpt_pkg::REG_STATUS, 8'hFF, 8'h00), 1, 8'h00, 0, 0);
    add_row(mk(vrpt_pkg::OP_WRITE, vrpt_pkg::REG_SCROLL, 8'hFF, 8'h00), 1, 8'h00, 0, 0);
    add_row(mk(vrpt_pkg::OP_WRITE, vrpt_pkg::REG_ADDR, 8'hFF, 8'h00), 0, 0, 0, 0);
    add_row(mk(vrpt_pkg::OP_WRITE, vrpt_pkg::REG_ADDR, 8'h10, 8'h00), 0, 0, 0, 0);
    add_row(mk(vrpt_pkg::OP_WRITE, vrpt_pkg::REG_DATA, 8'hA5, 8'h00), 0, 0, 0, 0);
    add_row(mk(vrpt_pkg::OP_WRITE, vrpt_pkg::REG_ADDR, 8'h3F, 8'h00), 0, 0, 0, 0);
    add_row(mk(vrpt_pkg::OP_WRITE, vrpt_pkg::REG_ADDR, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(vrpt_pkg::OP_READ, vrpt_pkg::REG_DATA, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(vrpt_pkg::OP_WRITE, vrpt_pkg::REG_ADDR, 8'h30, 8'h00), 0, 0, 0, 0);
    add_row(mk(vrpt_pkg::OP_WRITE, vrpt_pkg::REG_ADDR, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(vrpt_pkg::OP_READ, vrpt_pkg::REG_DATA, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(vrpt_pkg::OP_READ, vrpt_pkg::REG_DATA, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(vrpt_pkg::OP_WRITE, vrpt_pkg::REG_CTRL, 8'h84, 8'h00), 0, 0, 0, 0);
    add_row(mk(vrpt_pkg::OP_WRITE, vrpt_pkg::REG_MASK, 8'h10, 8'h00), 0, 0, 0, 0);
    add_row(mk(vrpt_pkg::OP_TICK, 3'd0, 8'h00, 8'hFF), 0, 0, 0, 0);
    add_row(mk(vrpt_pkg::OP_TICK, 3'd0, 8'h00, 8'h00), 0, 0, 0, 0);
    // walk a whole frame: sprite zero hit, vblank with nmi, nmi enable edge, wrap
    for (k = 0; k < 100; k++)
      add_row(mk(vrpt_pkg::OP_TICK, 3'd0, 8'h00, 8'hFF), 0, 0, 0, 0);
    add_row(mk(vrpt_pkg::OP_READ, vrpt_pkg::REG_STATUS, 8'h00, 8'h00), 0, 0, 0, 0);
    for (k = 0; k < 230; k++)
      add_row(mk(vrpt_pkg::OP_TICK, 3'd0, 8'h00, 8'hFF), 0, 0, 0, 0);
    add_row(mk(vrpt_pkg::OP_WRITE, vrpt_pkg::REG_CTRL, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(vrpt_pkg::OP_WRITE, vrpt_pkg::REG_CTRL, 8'h80, 8'h00), 0, 0, 0, 0);
    add_row(mk(vrpt_pkg::OP_READ, vrpt_pkg::REG_STATUS, 8'h00, 8'h00), 0, 0, 0, 0);
    for (k = 0; k < 30; k++)
      add_row(mk(vrpt_pkg::OP_TICK, 3'd0, 8'h00, 8'hFF), 0, 0, 0, 0);

    // each row is predicted; typed-in rows are also held against the table
    foreach (rows[i]) begin
      feed.push_back(rows[i].acc);
    end
    begin
      clear_shadow();
      foreach (rows[i]) begin
        chk = predict_access(rows[i].acc);
        if (rows[i].known && (chk.rbyte !== rows[i].rep.rbyte ||
                              chk.nmi !== rows[i].rep.nmi ||
                              chk.frame !== rows[i].rep.frame)) begin
          $error("table row %0d expected %0h actual %0h", i, rows[i].rep.rbyte, chk.rbyte);
          errors++;
        end
      end
      clear_shadow();
    end
    drain();

    // four idling mixes (none, sender only, receiver only, both) over both mirrorings
    random_phase(175, 0, 0);
    set_mirror(1);
    random_phase(175, 79, 0);
    random_phase(175, 0, 79);
    set_mirror(0);
    random_phase(175, 32, 32);

    // long receiver hold-off while the sender keeps offering
    hold_req = 1;
    random_phase(175, 0, 0);
    set_mirror(1);
    random_phase(175, 0, 0);

    $display("covered %0d replies, %0d frame wraps, a full frame with vblank and nmi,",
             replies_seen, frames_seen);
    $display("both mirrorings, four idling mixes and a long receiver hold-off");
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/vrpt_pkg.sv
rtl/vrpt_front.sv
rtl/vrpt_back.sv
rtl/video_register_port_and_timing.sv
sim/tb_top.sv
